### rtl/scaled_glyph_scanline_renderer_core_assert.svh
// Assertion macros for the scaled glyph scanline renderer.
// Used by the top level; expects clk and rst_n in the enclosing scope.
`ifndef SCALED_GLYPH_SCANLINE_RENDERER_CORE_ASSERT_SVH
`define SCALED_GLYPH_SCANLINE_RENDERER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising edge outside reset.
`define SCGR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scgr: same-cycle property violated");
// Next-cycle implication, checked at every rising edge outside reset.
`define SCGR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scgr: next-cycle property violated");
`else
`define SCGR_ASSERT_IMP(lbl, ante, cons)
`define SCGR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/scgr_pkg.sv
// Shared constants, register codes and types of the glyph scanline renderer.
// No dependencies; the register file, font store, engine, top level and testbench import it.
package scgr_pkg;

  // Glyph geometry and magnification limits.
  localparam int GLYPH_SIZE     = 8;
  localparam int GLYPH_COLS     = 8;
  localparam int MAX_SCALE      = 8;
  localparam int FONT_CHARS_DEF = 128;

  // Input word kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_BASE_OFFSET = 3'd0;
  localparam logic [2:0] REG_BPP         = 3'd1;
  localparam logic [2:0] REG_LINE_PITCH  = 3'd2;
  localparam logic [2:0] REG_SCREEN_SIZE = 3'd3;
  localparam logic [2:0] REG_RED_SHIFT   = 3'd4;
  localparam logic [2:0] REG_GREEN_SHIFT = 3'd5;
  localparam logic [2:0] REG_BLUE_SHIFT  = 3'd6;
  localparam logic [2:0] REG_ALPHA_SHIFT = 3'd7;

  // Current configuration as seen by the draw engine.
  typedef struct packed {
    logic [27:0] base_offset;
    logic [2:0]  bytes_per_pixel;
    logic [15:0] line_pitch;
    logic [27:0] screen_size;
    logic [4:0]  red_shift;
    logic [4:0]  green_shift;
    logic [4:0]  blue_shift;
    logic [4:0]  alpha_shift;
  } cfg_t;

  // Engine status, watched by the checks at the top level.
  typedef struct packed {
    logic idle;
    logic hold_valid;
  } stat_t;

endpackage

### rtl/scgr_if.sv
// Handshake channels of the glyph scanline renderer: input, result and
// configuration write. No dependencies.
interface scgr_in_if;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [6:0]        char_code;
  logic [2:0]        glyph_row;
  logic [7:0]        row_bits;
  logic signed [12:0] origin_x;
  logic signed [12:0] origin_y;
  logic [3:0]        scale;
  logic [5:0]        subrow;
  logic [7:0]        red;
  logic [7:0]        green;
  logic [7:0]        blue;
  logic [7:0]        alpha;

  modport source (output valid, kind, char_code, glyph_row, row_bits, origin_x, origin_y,
                  scale, subrow, red, green, blue, alpha, input ready);
  modport sink (input valid, kind, char_code, glyph_row, row_bits, origin_x, origin_y,
                scale, subrow, red, green, blue, alpha, output ready);
endinterface

interface scgr_out_if;
  logic        valid;
  logic        ready;
  logic [27:0] address;
  logic [31:0] pixel_word;
  logic        last;

  modport source (output valid, address, pixel_word, last, input ready);
  modport sink (input valid, address, pixel_word, last, output ready);
endinterface

interface scgr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [27:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/scgr_font_mem.sv
// Font store: one synchronous memory of glyph rows, one write and one read port.
// Depends on scgr_pkg for the glyph height.
module scgr_font_mem
  import scgr_pkg::*;
#(
  parameter int FONT_CHARS = FONT_CHARS_DEF
) (
  input  logic                                            clk,
  input  logic                                            we,
  input  logic [((FONT_CHARS > 1) ? $clog2(FONT_CHARS) : 1) + 2:0] waddr,
  input  logic [7:0]                                      wdata,
  input  logic                                            re,
  input  logic [((FONT_CHARS > 1) ? $clog2(FONT_CHARS) : 1) + 2:0] raddr,
  output logic [7:0]                                      rdata
);

  localparam int DEPTH = FONT_CHARS * GLYPH_SIZE;

  logic [7:0] font_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      font_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= font_r[raddr];
    end
  end

endmodule

### rtl/scgr_cfg_regs.sv
// Configuration register file of the glyph scanline renderer.
// Depends on scgr_pkg and the scgr_cfg_if channel.
module scgr_cfg_regs
  import scgr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  scgr_cfg_if.sink         cfg_chan,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_chan.ready = 1'b1;
  assign cfg = cfg_r;

  // Decode a write word into the addressed register.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_BASE_OFFSET: cfg_nxt.base_offset     = cfg_chan.data;
        REG_BPP:         cfg_nxt.bytes_per_pixel = cfg_chan.data[2:0];
        REG_LINE_PITCH:  cfg_nxt.line_pitch      = cfg_chan.data[15:0];
        REG_SCREEN_SIZE: cfg_nxt.screen_size     = cfg_chan.data;
        REG_RED_SHIFT:   cfg_nxt.red_shift       = cfg_chan.data[4:0];
        REG_GREEN_SHIFT: cfg_nxt.green_shift     = cfg_chan.data[4:0];
        REG_BLUE_SHIFT:  cfg_nxt.blue_shift      = cfg_chan.data[4:0];
        REG_ALPHA_SHIFT: cfg_nxt.alpha_shift     = cfg_chan.data[4:0];
      endcase
    end
  end

  // Registers with their reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_offset     <= 28'd0;
      cfg_r.bytes_per_pixel <= 3'd4;
      cfg_r.line_pitch      <= 16'd0;
      cfg_r.screen_size     <= 28'd0;
      cfg_r.red_shift       <= 5'd16;
      cfg_r.green_shift     <= 5'd8;
      cfg_r.blue_shift      <= 5'd0;
      cfg_r.alpha_shift     <= 5'd24;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/scgr_engine.sv
// Draw engine: takes input words, drives the font store ports, walks the
// scanline and issues pixel writes. Depends on scgr_pkg and scgr_if.
module scgr_engine
  import scgr_pkg::*;
#(
  parameter int FONT_CHARS = FONT_CHARS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  cfg_t                                            cfg,
  scgr_in_if.sink                                         in_chan,
  scgr_out_if.source                                      out_chan,
  output logic                                            mem_we,
  output logic [((FONT_CHARS > 1) ? $clog2(FONT_CHARS) : 1) + 2:0] mem_waddr,
  output logic [7:0]                                      mem_wdata,
  output logic                                            mem_re,
  output logic [((FONT_CHARS > 1) ? $clog2(FONT_CHARS) : 1) + 2:0] mem_raddr,
  input  logic [7:0]                                      mem_rdata,
  output stat_t                                           stat
);

  localparam int CHAR_AW = (FONT_CHARS > 1) ? $clog2(FONT_CHARS) : 1;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_BASE  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic signed [12:0] ox_r, ox_nxt;
  logic signed [13:0] py_r, py_nxt;
  logic [3:0]         scale_r, scale_nxt;
  logic [31:0]        word_r, word_nxt;
  logic [7:0]         glyph_r, glyph_nxt;
  logic signed [30:0] prod_r, prod_nxt;
  logic signed [16:0] oxb_r, oxb_nxt;
  logic [6:0]         colstep_r, colstep_nxt;
  logic signed [31:0] loc_r, loc_nxt;
  logic signed [31:0] col_base_r, col_base_nxt;
  logic [2:0]         col_r, col_nxt;
  logic [2:0]         sub_r, sub_nxt;
  logic               hold_v_r, hold_v_nxt;
  logic [27:0]        hold_addr_r, hold_addr_nxt;
  logic               out_v_r, out_v_nxt;
  logic [27:0]        out_addr_r, out_addr_nxt;
  logic [31:0]        out_word_r, out_word_nxt;
  logic               out_last_r, out_last_nxt;

  logic               in_ready;
  logic               in_acc;
  logic [7:0]         ch_ext;
  logic               ch_ok;
  logic [3:0]         scale_eff;
  logic [7:0]         ge;
  logic [2:0]         row_idx;
  logic               draw_go;
  logic               out_free;
  logic               col_set;
  logic               in_bnd;
  logic               cand;
  logic               col_done;
  logic               stall;
  logic signed [31:0] next_col_base;

  assign in_ready      = (state_r == ST_IDLE);
  assign in_chan.ready = in_ready;
  assign in_acc        = in_chan.valid && in_ready;

  // Character range check against the store size.
  assign ch_ext = {1'b0, in_chan.char_code};
  assign ch_ok  = (9'(ch_ext) < 9'(FONT_CHARS));

  // Magnification clamped to one through the largest scale.
  always_comb begin
    priority if (in_chan.scale == 4'd0) begin
      scale_eff = 4'd1;
    end else if (in_chan.scale > 4'(MAX_SCALE)) begin
      scale_eff = 4'(MAX_SCALE);
    end else begin
      scale_eff = in_chan.scale;
    end
  end

  // Glyph row of the scanline: count the row boundaries at or below subrow.
  // The eighth boundary marks a scanline below the cell.
  always_comb begin
    row_idx = 3'd0;
    for (int k = 0; k < GLYPH_SIZE; k++) begin
      ge[k] = ({1'b0, in_chan.subrow} >= 7'((k + 1) * scale_eff));
    end
    for (int k = 0; k < GLYPH_SIZE - 1; k++) begin
      row_idx = row_idx + 3'(ge[k]);
    end
  end

  assign draw_go = in_acc && (in_chan.kind == KIND_DRAW) && ch_ok && !ge[GLYPH_SIZE - 1];

  // Font store access. A load writes at its accept edge; a draw reads at its
  // own accept edge, always later, so a read never overlaps a pending write.
  assign mem_we    = in_acc && (in_chan.kind == KIND_LOAD) && ch_ok;
  assign mem_waddr = {ch_ext[CHAR_AW-1:0], in_chan.glyph_row};
  assign mem_wdata = in_chan.row_bits;
  assign mem_re    = draw_go;
  assign mem_raddr = {ch_ext[CHAR_AW-1:0], row_idx};

  // Scan position tests.
  assign out_free      = !out_v_r || out_chan.ready;
  assign col_set       = glyph_r[col_r];
  assign in_bnd        = !loc_r[31] && (loc_r[30:0] < {3'b000, cfg.screen_size});
  assign cand          = col_set && in_bnd;
  assign col_done      = !col_set || ({1'b0, sub_r} == (scale_r - 4'd1));
  assign stall         = cand && hold_v_r && !out_free;
  assign next_col_base = col_base_r + $signed({25'd0, colstep_r});

  // Sequencer and datapath next values.
  always_comb begin
    state_nxt     = state_r;
    ox_nxt        = ox_r;
    py_nxt        = py_r;
    scale_nxt     = scale_r;
    word_nxt      = word_r;
    glyph_nxt     = glyph_r;
    prod_nxt      = prod_r;
    oxb_nxt       = oxb_r;
    colstep_nxt   = colstep_r;
    loc_nxt       = loc_r;
    col_base_nxt  = col_base_r;
    col_nxt       = col_r;
    sub_nxt       = sub_r;
    hold_v_nxt    = hold_v_r;
    hold_addr_nxt = hold_addr_r;
    out_v_nxt     = out_v_r && !out_chan.ready;
    out_addr_nxt  = out_addr_r;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        // Capture the draw word; the pixel row is the cell top plus subrow.
        if (in_acc) begin
          ox_nxt    = in_chan.origin_x;
          py_nxt    = $signed({in_chan.origin_y[12], in_chan.origin_y}) +
                      $signed({8'd0, in_chan.subrow});
          scale_nxt = scale_eff;
          word_nxt  = (32'(in_chan.red) << cfg.red_shift) |
                      (32'(in_chan.green) << cfg.green_shift) |
                      (32'(in_chan.blue) << cfg.blue_shift) |
                      (32'(in_chan.alpha) << cfg.alpha_shift);
          if (draw_go) begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        // Row and column products, each registered before the sum.
        glyph_nxt   = mem_rdata;
        prod_nxt    = py_r * $signed({1'b0, cfg.line_pitch});
        oxb_nxt     = ox_r * $signed({1'b0, cfg.bytes_per_pixel});
        colstep_nxt = 7'(scale_r) * 7'(cfg.bytes_per_pixel);
        state_nxt   = ST_BASE;
      end
      ST_BASE: begin
        // Address of the first sub-column of glyph column zero.
        loc_nxt      = $signed({4'd0, cfg.base_offset}) + 32'(prod_r) + 32'(oxb_r);
        col_base_nxt = $signed({4'd0, cfg.base_offset}) + 32'(prod_r) + 32'(oxb_r);
        col_nxt      = 3'd0;
        sub_nxt      = 3'd0;
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        // One position a cycle while no write is stalled; an empty column is skipped as a single position.
        // The newest in-bounds write waits in the hold stage until a later
        // one or the end of the scan decides whether it is the last.
        if (!stall) begin
          if (cand) begin
            hold_v_nxt    = 1'b1;
            hold_addr_nxt = loc_r[27:0];
            if (hold_v_r) begin
              out_v_nxt    = 1'b1;
              out_addr_nxt = hold_addr_r;
              out_word_nxt = word_r;
              out_last_nxt = 1'b0;
            end
          end
          if (col_done) begin
            col_base_nxt = next_col_base;
            loc_nxt      = next_col_base;
            sub_nxt      = 3'd0;
            col_nxt      = col_r + 3'd1;
            if (col_r == 3'(GLYPH_COLS - 1)) begin
              state_nxt = ST_FLUSH;
            end
          end else begin
            sub_nxt = sub_r + 3'd1;
            loc_nxt = loc_r + $signed({29'd0, cfg.bytes_per_pixel});
          end
        end
      end
      ST_FLUSH: begin
        // Release the held write marked as the last one.
        if (!hold_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_v_nxt    = 1'b1;
          out_addr_nxt = hold_addr_r;
          out_word_nxt = word_r;
          out_last_nxt = 1'b1;
          hold_v_nxt   = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    ox_r        <= ox_nxt;
    py_r        <= py_nxt;
    scale_r     <= scale_nxt;
    word_r      <= word_nxt;
    glyph_r     <= glyph_nxt;
    prod_r      <= prod_nxt;
    oxb_r       <= oxb_nxt;
    colstep_r   <= colstep_nxt;
    loc_r       <= loc_nxt;
    col_base_r  <= col_base_nxt;
    col_r       <= col_nxt;
    sub_r       <= sub_nxt;
    hold_addr_r <= hold_addr_nxt;
    out_addr_r  <= out_addr_nxt;
    out_word_r  <= out_word_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_chan.valid      = out_v_r;
  assign out_chan.address    = out_addr_r;
  assign out_chan.pixel_word = out_word_r;
  assign out_chan.last       = out_last_r;

  assign stat.idle       = in_ready;
  assign stat.hold_valid = hold_v_r;

endmodule

### rtl/scaled_glyph_scanline_renderer_core.sv
// Scaled glyph scanline renderer. A load word, or a draw outside the cell or
// the store, leaves the engine idle and ready for a new word; any other draw
// runs through accept, font read, address setup, the scan positions (one per
// cycle unless the output stalls) and the release of the last write, and
// blocks the input until it is done. Reset restores the configuration
// defaults and empties the pipeline; the font store is kept.
`include "scaled_glyph_scanline_renderer_core_assert.svh"
module scaled_glyph_scanline_renderer_core
  import scgr_pkg::*;
#(
  parameter int FONT_CHARS = FONT_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  scgr_in_if.sink     in_chan,
  scgr_out_if.source  out_chan,
  scgr_cfg_if.sink    cfg_chan
);

  localparam int MEM_AW = ((FONT_CHARS > 1) ? $clog2(FONT_CHARS) : 1) + 3;

  cfg_t              cfg;
  stat_t             stat;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [MEM_AW-1:0] mem_raddr;
  logic [7:0]        mem_rdata;

  // Configuration registers.
  scgr_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  // Font store.
  scgr_font_mem #(
    .FONT_CHARS (FONT_CHARS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Draw engine.
  scgr_engine #(
    .FONT_CHARS (FONT_CHARS)
  ) u_eng (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .stat      (stat)
  );

  // A load word never produces a write.
  `SCGR_ASSERT_NXT(a_load_silent, in_chan.valid && in_chan.ready && in_chan.kind == KIND_LOAD && !out_chan.valid, !out_chan.valid)
  // The hold stage is empty whenever the engine takes new words.
  `SCGR_ASSERT_IMP(a_idle_hold_empty, stat.idle, !stat.hold_valid)
  // A draw starts with an empty hold stage; one inside the cell and the store also blocks the input.
  `SCGR_ASSERT_NXT(a_draw_start, in_chan.valid && in_chan.ready && in_chan.kind == KIND_DRAW, !stat.hold_valid)

endmodule

### tb/tb_top.sv
// Testbench for the scaled glyph scanline renderer: loads glyph rows, draws
// scanlines and checks every framebuffer write against its own prediction.
// Depends on scgr_pkg, the channel interfaces in scgr_if and the core.
`timescale 1ns / 100ps

module tb_top;
  import scgr_pkg::*;

  localparam int DRAIN_CYCLES = 100;
  localparam int QUIET_LIMIT  = 2000;
  localparam int MAX_REPORTS  = 100;
  localparam int HOLD_CYCLES  = 300;

  // One input word and one framebuffer write as the testbench sees them.
  typedef struct {
    logic               kind;
    logic [6:0]         char_code;
    logic [2:0]         glyph_row;
    logic [7:0]         row_bits;
    logic signed [12:0] origin_x;
    logic signed [12:0] origin_y;
    logic [3:0]         scale;
    logic [5:0]         subrow;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
  } glyph_word_t;

  typedef struct {
    logic [27:0] address;
    logic [31:0] pixel_word;
    logic        last;
  } fb_write_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  scgr_in_if  in_bus ();
  scgr_out_if out_bus ();
  scgr_cfg_if cfg_bus ();

  scaled_glyph_scanline_renderer_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  // Mirror of the block: font contents, written flags and live configuration.
  logic [7:0] glyph_rows [0:1023];
  bit         row_written [0:1023];
  bit         glyph_full [0:127];
  int         full_chars[$];
  cfg_t       panel_cfg;
  fb_write_t  pending_writes[$];

  int mismatch_count     = 0;
  int sender_gap_pct     = 0;
  int receiver_stall_pct = 0;
  int receiver_hold      = 0;
  int quiet_cycles       = 0;

  always #5 clk = ~clk;

  // Mismatch reporting: one line each, printing capped to keep the log short.
  task automatic report_mismatch(string what);
    if (mismatch_count < MAX_REPORTS) begin
      $display("tb_top: mismatch at %0t: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // Predicts the effect of one accepted word: a load updates the font copy,
  // a draw queues the framebuffer writes of its scanline.
  function automatic void render_scanline(glyph_word_t w);
    fb_write_t  line_q[$];
    fb_write_t  wr;
    int         sc, row, sub, idx;
    bit         complete;
    logic [7:0] bits;
    logic [31:0] word;
    longint     py, rowbase, px, loc;

    if (w.kind == KIND_LOAD) begin
      idx = {w.char_code, w.glyph_row};
      glyph_rows[idx]  = w.row_bits;
      row_written[idx] = 1'b1;
      complete = 1'b1;
      for (int r = 0; r < GLYPH_SIZE; r++) begin
        if (!row_written[w.char_code * GLYPH_SIZE + r]) complete = 1'b0;
      end
      if (complete && !glyph_full[w.char_code]) begin
        glyph_full[w.char_code] = 1'b1;
        full_chars.push_back(w.char_code);
      end
      return;
    end

    // Zero scale counts as one; anything above the limit saturates.
    sc = int'(w.scale);
    if (sc == 0) sc = 1;
    if (sc > MAX_SCALE) sc = MAX_SCALE;
    row = int'(w.subrow) / sc;
    sub = int'(w.subrow) % sc;
    if (row >= GLYPH_SIZE) return;
    bits = glyph_rows[w.char_code * GLYPH_SIZE + row];

    word = (32'(w.red) << panel_cfg.red_shift) | (32'(w.green) << panel_cfg.green_shift)
         | (32'(w.blue) << panel_cfg.blue_shift) | (32'(w.alpha) << panel_cfg.alpha_shift);

    py      = longint'(w.origin_y) + longint'(row * sc + sub);
    rowbase = longint'(panel_cfg.base_offset) + py * longint'(panel_cfg.line_pitch);

    // Walk columns, then sub-columns; writes outside the screen are dropped.
    for (int col = 0; col < GLYPH_COLS; col++) begin
      if (bits[col]) begin
        for (int k = 0; k < sc; k++) begin
          px  = longint'(w.origin_x) + longint'(col * sc + k);
          loc = rowbase + px * longint'(panel_cfg.bytes_per_pixel);
          if (loc >= 0 && loc < longint'(panel_cfg.screen_size)) begin
            wr.address    = loc[27:0];
            wr.pixel_word = word;
            wr.last       = 1'b0;
            line_q.push_back(wr);
          end
        end
      end
    end
    if (line_q.size() > 0) line_q[line_q.size() - 1].last = 1'b1;
    foreach (line_q[i]) pending_writes.push_back(line_q[i]);
  endfunction

  // Word builders for directed items; unused fields carry random values.
  function automatic glyph_word_t load_word(int ch, int row, logic [7:0] bits);
    glyph_word_t w;
    w.kind      = KIND_LOAD;
    w.char_code = 7'(ch);
    w.glyph_row = 3'(row);
    w.row_bits  = bits;
    w.origin_x  = 13'($urandom);
    w.origin_y  = 13'($urandom);
    w.scale     = 4'($urandom);
    w.subrow    = 6'($urandom);
    {w.red, w.green, w.blue, w.alpha} = $urandom;
    return w;
  endfunction

  function automatic glyph_word_t draw_word(int ch, int ox, int oy, int scale, int subrow,
                                            logic [31:0] rgba);
    glyph_word_t w;
    w.kind      = KIND_DRAW;
    w.char_code = 7'(ch);
    w.glyph_row = 3'($urandom);
    w.row_bits  = 8'($urandom);
    w.origin_x  = 13'(ox);
    w.origin_y  = 13'(oy);
    w.scale     = 4'(scale);
    w.subrow    = 6'(subrow);
    {w.red, w.green, w.blue, w.alpha} = rgba;
    return w;
  endfunction

  // Random word: mostly draws of complete glyphs inside the cell, some loads,
  // some arbitrary values. A draw that would read an unwritten row becomes
  // a load of that row instead.
  function automatic glyph_word_t random_word();
    glyph_word_t w;
    int sc, row;
    w.kind      = ($urandom_range(4) == 0) ? KIND_LOAD : KIND_DRAW;
    w.char_code = 7'($urandom);
    w.glyph_row = 3'($urandom);
    w.row_bits  = 8'($urandom);
    {w.red, w.green, w.blue, w.alpha} = $urandom;
    if ($urandom_range(5) == 0) begin
      w.origin_x = 13'($urandom);
      w.origin_y = 13'($urandom);
    end else begin
      w.origin_x = 13'($urandom_range(0, 300));
      w.origin_y = 13'($urandom_range(0, 300));
    end
    w.scale = ($urandom_range(8) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
    sc = int'(w.scale);
    if (sc == 0) sc = 1;
    if (sc > MAX_SCALE) sc = MAX_SCALE;
    w.subrow = ($urandom_range(5) == 0) ? 6'($urandom) : 6'($urandom_range(0, 8 * sc - 1));
    if (w.kind == KIND_DRAW) begin
      if (full_chars.size() > 0 && $urandom_range(3) != 0) begin
        w.char_code = 7'(full_chars[$urandom_range(full_chars.size() - 1)]);
      end
      row = int'(w.subrow) / sc;
      if (row < GLYPH_SIZE && !row_written[w.char_code * GLYPH_SIZE + row]) begin
        w.kind      = KIND_LOAD;
        w.glyph_row = 3'(row);
      end
    end
    return w;
  endfunction

  function automatic cfg_t random_setting();
    cfg_t s;
    s.base_offset     = 28'($urandom_range(0, 8192));
    s.bytes_per_pixel = 3'($urandom_range(1, 4));
    s.line_pitch      = 16'($urandom_range(1024, 8192));
    s.screen_size     = 28'($urandom_range(1 << 20, 1 << 24));
    s.red_shift       = 5'($urandom);
    s.green_shift     = 5'($urandom);
    s.blue_shift      = 5'($urandom);
    s.alpha_shift     = 5'($urandom);
    return s;
  endfunction

  // Sends one word with random idle gaps ahead of it and predicts it once
  // accepted. Valid stays high afterwards until the next gap or settle.
  task automatic send_word(glyph_word_t w);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.kind      <= w.kind;
    in_bus.char_code <= w.char_code;
    in_bus.glyph_row <= w.glyph_row;
    in_bus.row_bits  <= w.row_bits;
    in_bus.origin_x  <= w.origin_x;
    in_bus.origin_y  <= w.origin_y;
    in_bus.scale     <= w.scale;
    in_bus.subrow    <= w.subrow;
    in_bus.red       <= w.red;
    in_bus.green     <= w.green;
    in_bus.blue      <= w.blue;
    in_bus.alpha     <= w.alpha;
    in_bus.valid     <= 1'b1;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    render_scanline(w);
  endtask

  // Stops sending, waits for every expected write, then lets a possible
  // draw with no surviving writes run out.
  task automatic settle_block();
    in_bus.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; valid is left high for the next one.
  task automatic write_reg(logic [2:0] index, logic [27:0] data);
    cfg_bus.index <= index;
    cfg_bus.data  <= data;
    cfg_bus.valid <= 1'b1;
    @(posedge clk);
    while (cfg_bus.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic apply_setting(cfg_t s);
    write_reg(REG_BASE_OFFSET, s.base_offset);
    write_reg(REG_BPP,         28'(s.bytes_per_pixel));
    write_reg(REG_LINE_PITCH,  28'(s.line_pitch));
    write_reg(REG_SCREEN_SIZE, s.screen_size);
    write_reg(REG_RED_SHIFT,   28'(s.red_shift));
    write_reg(REG_GREEN_SHIFT, 28'(s.green_shift));
    write_reg(REG_BLUE_SHIFT,  28'(s.blue_shift));
    write_reg(REG_ALPHA_SHIFT, 28'(s.alpha_shift));
    cfg_bus.valid <= 1'b0;
    panel_cfg = s;
  endtask

  // Fills glyph 0 and two rows of glyph 127 with edge patterns, then draws once
  // with the reset configuration, whose empty screen drops every write.
  task automatic test_glyph_loads();
    send_word(load_word(0, 0, 8'h00));
    send_word(load_word(0, 1, 8'hFF));
    send_word(load_word(0, 2, 8'h01));
    send_word(load_word(0, 3, 8'h80));
    send_word(load_word(0, 4, 8'hA5));
    send_word(load_word(0, 5, 8'h5A));
    send_word(load_word(0, 6, 8'h3C));
    send_word(load_word(0, 7, 8'hFF));
    send_word(load_word(127, 0, 8'hFF));
    send_word(load_word(127, 7, 8'h81));
    send_word(draw_word(0, 0, 0, 1, 1, 32'hFFFFFFFF));
    settle_block();
  endtask

  // Directed draws: scale limits, subrow outside the cell, empty rows,
  // clipping at both ends of the field range.
  task automatic test_draw_cases();
    apply_setting('{28'd0, 3'd4, 16'd4096, 28'hFFFFFFF, 5'd0, 5'd8, 5'd16, 5'd24});
    send_word(draw_word(0, 0, 0, 1, 1, 32'hFFFFFFFF));
    send_word(draw_word(0, 10, 5, 0, 4, 32'h00000000));
    send_word(draw_word(0, 100, 100, 15, 63, 32'h12345678));
    send_word(draw_word(0, 0, 0, 2, 20, $urandom));
    send_word(draw_word(0, 0, 0, 1, 0, $urandom));
    send_word(draw_word(0, -2, 0, 1, 1, $urandom));
    send_word(draw_word(127, -4096, -4096, 8, 0, $urandom));
    send_word(draw_word(127, 4095, 4095, 8, 63, 32'hFFFFFFFF));
    send_word(draw_word(0, 37, 2, 3, 14, $urandom));
    send_word(draw_word(0, 5, 5, 4, 13, $urandom));
    settle_block();
  endtask

  // Register extremes: maximal panning, zero and odd pixel sizes, full-width
  // lines, tight screens and channel shifts at both ends.
  task automatic test_register_extremes();
    cfg_t extremes [4];
    extremes[0] = '{28'hFFFFFFF, 3'd1, 16'd0, 28'hFFFFFFF, 5'd31, 5'd31, 5'd31, 5'd31};
    extremes[1] = '{28'd0, 3'd7, 16'hFFFF, 28'd3000000, 5'd0, 5'd8, 5'd16, 5'd24};
    extremes[2] = '{28'd100, 3'd0, 16'd1, 28'd1000, 5'd24, 5'd16, 5'd8, 5'd0};
    extremes[3] = '{28'd0, 3'd2, 16'd640, 28'd307200, 5'd3, 5'd11, 5'd19, 5'd27};
    foreach (extremes[i]) begin
      apply_setting(extremes[i]);
      send_word(draw_word(0, -4, 0, 1, 1, $urandom));
      send_word(draw_word(0, 3, 44, 15, 63, 32'hFFFFFFFF));
      send_word(draw_word(127, -4096, -4096, 8, 0, $urandom));
      send_word(draw_word(0, 4095, 4095, 2, 9, 32'h00000000));
      settle_block();
    end
  endtask

  // Random traffic under a fresh configuration; now and then a whole glyph
  // is loaded so that later draws can use it.
  task automatic test_random_traffic(int items, int gap_pct, int stall_pct);
    int sent;
    int ch;
    sender_gap_pct     = gap_pct;
    receiver_stall_pct = stall_pct;
    apply_setting(random_setting());
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(7) == 0) begin
        ch = $urandom_range(127);
        for (int r = 0; r < GLYPH_SIZE; r++) send_word(load_word(ch, r, 8'($urandom)));
        sent += GLYPH_SIZE;
      end else begin
        send_word(random_word());
        sent++;
      end
    end
    settle_block();
  endtask

  // Receiver holds off for a long stretch while full-width draws keep
  // coming, so the block backs up and stops accepting words.
  task automatic test_backpressure();
    sender_gap_pct     = 0;
    receiver_stall_pct = 0;
    receiver_hold      = HOLD_CYCLES;
    for (int i = 0; i < 16; i++) begin
      send_word(draw_word(0, $urandom_range(0, 200), $urandom_range(0, 100), 8,
                          56 + (i % 8), $urandom));
    end
    settle_block();
  endtask

  // Result side: random stalls plus the long hold-off when one is requested.
  always @(posedge clk) begin
    if (receiver_hold > 0) begin
      receiver_hold <= receiver_hold - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Every accepted write is checked against the oldest expected one.
  always @(posedge clk) begin : check_writes
    fb_write_t due;
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected write address %h", out_bus.address));
      end else begin
        due = pending_writes.pop_front();
        if (out_bus.address !== due.address)
          report_mismatch($sformatf("address %h, expected %h", out_bus.address, due.address));
        if (out_bus.pixel_word !== due.pixel_word)
          report_mismatch($sformatf("pixel word %h, expected %h",
                                    out_bus.pixel_word, due.pixel_word));
        if (out_bus.last !== due.last)
          report_mismatch($sformatf("last %b, expected %b", out_bus.last, due.last));
      end
    end
  end

  // Watchdog: too long without any word moving on any channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid === 1'b1 && in_bus.ready === 1'b1)
        || (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
        || (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_bus.valid     = 1'b0;
    in_bus.kind      = KIND_LOAD;
    in_bus.char_code = '0;
    in_bus.glyph_row = '0;
    in_bus.row_bits  = '0;
    in_bus.origin_x  = '0;
    in_bus.origin_y  = '0;
    in_bus.scale     = '0;
    in_bus.subrow    = '0;
    in_bus.red       = '0;
    in_bus.green     = '0;
    in_bus.blue      = '0;
    in_bus.alpha     = '0;
    out_bus.ready    = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = REG_BASE_OFFSET;
    cfg_bus.data     = '0;
    panel_cfg        = '{28'd0, 3'd4, 16'd0, 28'd0, 5'd16, 5'd8, 5'd0, 5'd24};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_glyph_loads();
    test_draw_cases();
    test_register_extremes();
    test_random_traffic(25, 16, 73);
    test_random_traffic(25, 73, 16);
    test_random_traffic(25, 0, 0);
    test_backpressure();

    if (mismatch_count == 0 && pending_writes.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
